[hw/rtl/tse_pkg.sv]
`timescale 1ns / 1ps

package tse_pkg;

	localparam int COEF_DEPTH = 10;
	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] TERM_COUNT_RESET = 4'd10;

	localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [31:0] SINE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SINE_MIN = 32'sh8000_0000;

	// round(2^(60+4i) / (2i+1)!), restoring long division at elaboration
	function automatic logic [63:0] coef_calc(input int i);
		logic [63:0] den;
		logic [63:0] r;
		logic [63:0] q;
		int sh;
		den = 64'd1;
		for (int k = 2; k <= 2 * i + 1; k++) begin
			den = den * 64'(k);
		end
		r = '0;
		q = '0;
		sh = 60 + 4 * i;
		for (int b = sh; b >= 0; b--) begin
			r = {r[62:0], (b == sh)};
			q = {q[62:0], 1'b0};
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		if ({r, 1'b0} >= {1'b0, den}) begin
			q = q + 64'd1;
		end
		return q;
	endfunction

	localparam logic [63:0] COEF [COEF_DEPTH] = '{
		coef_calc(0), coef_calc(1), coef_calc(2), coef_calc(3), coef_calc(4),
		coef_calc(5), coef_calc(6), coef_calc(7), coef_calc(8), coef_calc(9)
	};

	typedef struct packed {
		logic             load;     // take angle, seed accumulator
		logic             square;   // b <= |x|^2
		logic             absval;   // capture |acc| and product sign
		logic             fin;      // final multiply by x
		logic             mul;      // one 32x32 partial product
		logic [1:0]       phase;
		logic             rnd;      // round and clamp the product
		logic             sub;      // Horner step: acc <= d_i - m
		logic             out;      // load output register
		logic             zero;     // zero terms: result is 0
		logic [CNT_W-1:0] coef_idx;
	} tse_cmd_t;

endpackage

[hw/rtl/tse_ctrl.sv]
`timescale 1ns / 1ps

module tse_ctrl
	import tse_pkg::*;
#(
	parameter int MAX_TERMS = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             term_count_wr_en,
	input  logic [CNT_W-1:0] term_count,
	output tse_cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ABS,
		ST_MUL,
		ST_RND,
		ST_SUB,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] term_count_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       phase_q;
	logic             fin_q;
	logic             zero_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] n_eff;
	logic             in_acc;

	assign n_eff = (term_count_q > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : term_count_q;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.fin = fin_q;
		cmd.zero = zero_q;
		cmd.phase = phase_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_acc;
				cmd.coef_idx = n_eff - CNT_W'(1);
			end
			ST_SQUARE: cmd.square = 1'b1;
			ST_ABS:    cmd.absval = 1'b1;
			ST_MUL:    cmd.mul = 1'b1;
			ST_RND:    cmd.rnd = 1'b1;
			ST_SUB: begin
				cmd.sub = 1'b1;
				cmd.coef_idx = cnt_q - CNT_W'(1);
			end
			ST_DONE:   cmd.out = !out_valid_q || out_ready;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			term_count_q <= TERM_COUNT_RESET;
			cnt_q <= '0;
			phase_q <= '0;
			fin_q <= 1'b0;
			zero_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (term_count_wr_en) begin
				term_count_q <= term_count;
			end
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (n_eff == '0) begin
							zero_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							zero_q <= 1'b0;
							cnt_q <= n_eff - CNT_W'(1);
							fin_q <= (n_eff == CNT_W'(1));
							state_q <= ST_SQUARE;
						end
					end
				end
				ST_SQUARE: state_q <= ST_ABS;
				ST_ABS: begin
					phase_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd3) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: state_q <= fin_q ? ST_DONE : ST_SUB;
				ST_SUB: begin
					cnt_q <= cnt_q - CNT_W'(1);
					fin_q <= (cnt_q == CNT_W'(1));
					state_q <= ST_ABS;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/tse_dpath.sv]
`timescale 1ns / 1ps

module tse_dpath
	import tse_pkg::*;
(
	input  logic               clk,
	input  tse_cmd_t           cmd,
	input  logic signed [31:0] angle,
	output logic signed [31:0] sine,
	output logic               saturated
);

	logic signed [31:0] x_q;
	logic [63:0]        b_q;
	logic signed [63:0] acc_q;
	logic [63:0]        am_q;
	logic               neg_q;
	logic [127:0]       prod_q;
	logic signed [63:0] m_q;
	logic signed [31:0] sine_q;
	logic               saturated_q;

	logic [31:0]        ax;
	logic [31:0]        opa;
	logic [31:0]        opb;
	logic [63:0]        pp;
	logic [127:0]       pp_sh;
	logic [127:0]       rsum;
	logic               over;
	logic [63:0]        mag;
	logic signed [63:0] rnd_val;
	logic signed [63:0] coef_v;
	logic signed [64:0] diff;
	logic signed [63:0] sub_val;
	logic               s_hi;
	logic               s_lo;

	assign ax = x_q[31] ? (~x_q + 32'd1) : x_q;

	// shared 32x32 multiplier
	always_comb begin
		if (cmd.square) begin
			opa = ax;
			opb = ax;
		end else begin
			opa = cmd.phase[1] ? am_q[63:32] : am_q[31:0];
			opb = cmd.phase[0] ? b_q[63:32] : b_q[31:0];
		end
	end
	assign pp = 64'(opa) * 64'(opb);

	always_comb begin
		case (cmd.phase)
			2'd0:    pp_sh = {64'd0, pp};
			2'd1:    pp_sh = {32'd0, pp, 32'd0};
			2'd2:    pp_sh = {32'd0, pp, 32'd0};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = '0;
		endcase
	end

	// round to nearest on magnitude, shift by 61 for the final product, else 62
	always_comb begin
		if (cmd.fin) begin
			rsum = prod_q + (128'd1 << 60);
			over = |rsum[127:125];
			mag = rsum[124:61];
		end else begin
			rsum = prod_q + (128'd1 << 61);
			over = |rsum[127:126];
			mag = rsum[125:62];
		end
		if (over || mag[63]) begin
			mag = ACC_MAX;
		end
		rnd_val = neg_q ? -$signed(mag) : $signed(mag);
	end

	assign coef_v = $signed(COEF[cmd.coef_idx]);
	assign diff = {coef_v[63], coef_v} - {m_q[63], m_q};
	always_comb begin
		if (diff[64] != diff[63]) begin
			sub_val = diff[64] ? ACC_MIN : ACC_MAX;
		end else begin
			sub_val = diff[63:0];
		end
	end

	assign s_hi = !m_q[63] && (m_q[62:31] != '0);
	assign s_lo = m_q[63] && (m_q[62:31] != '1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= angle;
			acc_q <= coef_v;
		end
		if (cmd.square) begin
			b_q <= pp;
		end
		if (cmd.absval) begin
			am_q <= acc_q[63] ? (~acc_q + 64'd1) : acc_q;
			neg_q <= acc_q[63] ^ (cmd.fin & x_q[31]);
			if (cmd.fin) begin
				b_q <= {32'd0, ax};
			end
		end
		if (cmd.mul) begin
			prod_q <= (cmd.phase == 2'd0) ? pp_sh : prod_q + pp_sh;
		end
		if (cmd.rnd) begin
			m_q <= rnd_val;
		end
		if (cmd.sub) begin
			acc_q <= sub_val;
		end
		if (cmd.out) begin
			if (cmd.zero) begin
				sine_q <= '0;
				saturated_q <= 1'b0;
			end else if (s_hi) begin
				sine_q <= SINE_MAX;
				saturated_q <= 1'b1;
			end else if (s_lo) begin
				sine_q <= SINE_MIN;
				saturated_q <= 1'b1;
			end else begin
				sine_q <= m_q[31:0];
				saturated_q <= 1'b0;
			end
		end
	end

	assign sine = sine_q;
	assign saturated = saturated_q;

endmodule

[hw/rtl/taylor_sine_evaluator_unit.sv]
`timescale 1ns / 1ps
// Truncated Taylor series sine, angle in Q2.29, result in Q3.28.
// Input channel: in_valid / in_ready with angle. Output channel: out_valid /
// out_ready with sine and saturated. A word is taken when valid and ready
// are both high at a rising edge.
// term_count is written with term_count_wr_en; write it only while idle.
// Evaluation is Horner form in x^2 on one shared 32x32 multiplier: each step
// takes the magnitude of the accumulator, builds the 64x64 product from four
// partial products, rounds it and subtracts it from the next coefficient.
// With n = min(term_count, MAX_TERMS) >= 1, in_ready stays low from
// acceptance until the result is loaded into the output register, so a new
// word is taken only after the last one is done. With n = 0 the result is zero.
// The result sits in an output register; the block returns to idle and takes
// the next word while it waits. If the receiver stalls, the next result is
// held in the datapath until the output register is taken.
// Reset clears the controller, drops out_valid and sets term_count to 10.
module taylor_sine_evaluator_unit
	import tse_pkg::*;
#(
	parameter int MAX_TERMS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sine,
	output logic               saturated,
	input  logic               term_count_wr_en,
	input  logic [CNT_W-1:0]   term_count
);

	tse_cmd_t cmd;

	tse_ctrl #(
		.MAX_TERMS(MAX_TERMS)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.term_count_wr_en (term_count_wr_en),
		.term_count       (term_count),
		.cmd              (cmd)
	);

	tse_dpath u_dpath (
		.clk       (clk),
		.cmd       (cmd),
		.angle     (angle),
		.sine      (sine),
		.saturated (saturated)
	);

endmodule

[tb/tb_taylor_sine_evaluator_unit.sv]
`timescale 1ns / 1ps

module tb_taylor_sine_evaluator_unit;
	import tse_pkg::*;

	localparam int SERIES_MAX_TERMS = 10;
	localparam logic signed [31:0] HALF_PI_Q229 = 32'sh3243_F6A9;
	localparam logic signed [31:0] PI_Q229 = 32'sh6487_ED51;
	localparam logic signed [63:0] SINE_TOP = 64'sd2147483647;
	localparam logic signed [63:0] SINE_BOTTOM = -64'sd2147483648;

	typedef struct {
		logic signed [31:0] angle;
		logic [CNT_W-1:0]   terms;
		logic signed [31:0] sine;
		logic               saturated;
	} sine_expect_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] angle = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] sine;
	logic               saturated;
	logic               term_count_wr_en = 1'b0;
	logic [CNT_W-1:0]   term_count = '0;

	sine_expect_t     pending_sines[$];
	logic [CNT_W-1:0] terms_setting = TERM_COUNT_RESET;
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;
	int               mismatch_count = 0;
	int               angles_sent = 0;
	int               results_checked = 0;
	int               settings_written = 0;

	taylor_sine_evaluator_unit #(
		.MAX_TERMS(SERIES_MAX_TERMS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.angle(angle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sine(sine),
		.saturated(saturated),
		.term_count_wr_en(term_count_wr_en),
		.term_count(term_count)
	);

	always #5 clk = ~clk;

	// round(2^(60+4i) / (2i+1)!) in Q4.60
	function automatic logic [63:0] series_coef(input int i);
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] q;
		num = 128'd1 << (60 + 4 * i);
		den = 128'd1;
		for (int k = 2; k <= 2 * i + 1; k++) begin
			den = den * k;
		end
		q = (num + (den >> 1)) / den;
		return q[63:0];
	endfunction

	// a*b / 2^sh rounded half away from zero, magnitude clamped to 2^63-1
	function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
			input logic signed [63:0] b, input int sh);
		logic         neg;
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [127:0] p;
		logic [63:0]  mag;
		neg = a[63] != b[63];
		ua = a[63] ? 64'd0 - a : a;
		ub = b[63] ? 64'd0 - b : b;
		p = {64'd0, ua} * {64'd0, ub};
		p = (p + (128'd1 << (sh - 1))) >> sh;
		if (p > 128'h7FFF_FFFF_FFFF_FFFF) begin
			mag = 64'h7FFF_FFFF_FFFF_FFFF;
		end else begin
			mag = p[63:0];
		end
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [63:0] clamped_diff(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] d;
		d = {a[63], a} - {b[63], b};
		if (d[64] != d[63]) begin
			return d[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return d[63:0];
	endfunction

	// Horner form in u = x^2, coefficients scaled by 16^i
	function automatic sine_expect_t predict_sine(input logic signed [31:0] x,
			input logic [CNT_W-1:0] terms);
		sine_expect_t       e;
		int                 n;
		logic signed [63:0] xw;
		logic signed [63:0] u;
		logic signed [63:0] acc;
		logic signed [63:0] s;
		e.angle = x;
		e.terms = terms;
		e.sine = '0;
		e.saturated = 1'b0;
		n = (terms > SERIES_MAX_TERMS) ? SERIES_MAX_TERMS : int'(terms);
		if (n == 0) begin
			return e;
		end
		xw = x;
		u = xw * xw;
		acc = series_coef(n - 1);
		for (int i = n - 2; i >= 0; i--) begin
			acc = clamped_diff(series_coef(i), scaled_product(acc, u, 62));
		end
		s = scaled_product(acc, xw, 61);
		if (s > SINE_TOP) begin
			e.sine = SINE_TOP[31:0];
			e.saturated = 1'b1;
		end else if (s < SINE_BOTTOM) begin
			e.sine = SINE_BOTTOM[31:0];
			e.saturated = 1'b1;
		end else begin
			e.sine = s[31:0];
		end
		return e;
	endfunction

	function automatic logic signed [31:0] random_angle();
		logic [31:0] r;
		logic [31:0] offset;
		r = $urandom;
		offset = $urandom_range(0, 1023);
		case ($urandom_range(0, 7))
			0: begin
				r = r[0] ? 32'd0 - offset : offset;
			end
			1: begin
				r = r[31] ? 32'h8000_0000 + offset : 32'h7FFF_FFFF - offset;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$display("%0t ns: %s", $time, what);
		end
	endtask

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
	endtask

	task automatic send_angle(input logic signed [31:0] a);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		angle <= a;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		pending_sines.push_back(predict_sine(a, terms_setting));
		angles_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_sines.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// write only once every result is out
	task automatic set_terms(input logic [CNT_W-1:0] n);
		wait_drained();
		term_count_wr_en <= 1'b1;
		term_count <= n;
		@(posedge clk);
		term_count_wr_en <= 1'b0;
		terms_setting = n;
		settings_written++;
	endtask

	// nothing written yet: the reset term count must apply
	task automatic check_reset_terms();
		send_angle('0);
		send_angle(32'sd1);
		send_angle(-32'sd1);
		send_angle(32'sh7FFF_FFFF);
		send_angle(32'sh8000_0000);
		send_angle(HALF_PI_Q229);
		send_angle(-PI_Q229);
	endtask

	task automatic check_zero_terms();
		set_terms('0);
		send_angle(32'sh7FFF_FFFF);
		send_angle(32'sh8000_0000);
	endtask

	// counts above the table size fall back to the full series
	task automatic check_excess_terms();
		set_terms(4'd11);
		send_angle(32'sh8000_0000);
		set_terms(4'd15);
		send_angle(32'sh7FFF_FFFF);
		send_angle(HALF_PI_Q229);
	endtask

	task automatic check_term_sweep();
		for (int n = 1; n < SERIES_MAX_TERMS; n++) begin
			set_terms(CNT_W'(n));
			send_angle(n[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
		end
	endtask

	task automatic check_random_angles();
		logic [CNT_W-1:0] n;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: set_idling(25, 58);
				1: set_idling(58, 25);
				default: set_idling(0, 0);
			endcase
			for (int phase = 0; phase < 6; phase++) begin
				if ($urandom_range(0, 3) == 0) begin
					n = CNT_W'($urandom_range(0, 15));
				end else begin
					n = CNT_W'($urandom_range(1, SERIES_MAX_TERMS));
				end
				set_terms(n);
				repeat (111) send_angle(random_angle());
			end
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : check_results
		sine_expect_t head;
		if (arst_n && out_valid && out_ready) begin
			if (pending_sines.size() == 0) begin
				report_mismatch($sformatf("result sine %h with no angle outstanding", sine));
			end else begin
				head = pending_sines.pop_front();
				results_checked++;
				if (sine !== head.sine) begin
					report_mismatch($sformatf("angle %h terms %0d: sine %h, want %h",
						head.angle, head.terms, sine, head.sine));
				end
				if (saturated !== head.saturated) begin
					report_mismatch($sformatf("angle %h terms %0d: saturated %b, want %b",
						head.angle, head.terms, saturated, head.saturated));
				end
			end
		end
	end

	initial begin
		int waited;
		waited = 0;
		set_idling(25, 58);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_reset_terms();
		check_zero_terms();
		check_excess_terms();
		check_term_sweep();
		check_random_angles();
		in_valid <= 1'b0;
		while (pending_sines.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (80) @(posedge clk);
		foreach (pending_sines[i]) begin
			report_mismatch($sformatf("angle %h terms %0d: no result arrived",
				pending_sines[i].angle, pending_sines[i].terms));
		end
		$display("Evaluated %0d angles over %0d term_count writes, %0d results compared.",
			angles_sent, settings_written, results_checked);
		$display("Covered zero, excess and full term counts under three stall patterns.");
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Timed out with %0d results outstanding", pending_sines.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

[taylor_sine_evaluator_unit.f]
hw/rtl/tse_pkg.sv
hw/rtl/tse_ctrl.sv
hw/rtl/tse_dpath.sv
hw/rtl/taylor_sine_evaluator_unit.sv
tb/tb_taylor_sine_evaluator_unit.sv
